>>> hw/rtl/cmf_pkg.sv
package cmf_pkg;

  localparam int CoordWidth = 16;
  localparam int UvWidth    = 16;
  // face-local coordinate, one bit wider to hold the negated most negative input
  localparam int SWidth     = CoordWidth + 1;
  // remainder and divisor width: divisor is 2k, up to 2^CoordWidth
  localparam int RemWidth   = CoordWidth + 1;
  // stages between input transfer and result: select, setup, one cell per bit, output register
  localparam int Latency    = UvWidth + 3;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  // data handed from one divider cell to the next
  typedef struct packed {
    logic                valid;
    face_t               face;
    logic                zero;
    logic                sat_u;
    logic                sat_v;
    logic [RemWidth-1:0] div;
    logic [RemWidth-1:0] rem_u;
    logic [RemWidth-1:0] rem_v;
    logic [UvWidth-1:0]  quo_u;
    logic [UvWidth-1:0]  quo_v;
  } cell_t;

endpackage

>>> hw/rtl/cube_map_face_and_uv.sv
// channel  ports                                     transfer
// input    in_dir_x, in_dir_y, in_dir_z              start && !busy
// result   out_face, out_tex_u, out_tex_v,           out_valid (one cycle)
//          out_zero_vector
//
// one direction is taken every cycle; busy is never raised
// each result passes from its input transfer through one select stage, one setup
// stage, one divider cell per coordinate bit and one output register
// synchronous active-low reset empties the pipeline; no result follows a reset
// the receiver cannot stall, so results stream out in input order
module cube_map_face_and_uv (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [cmf_pkg::CoordWidth-1:0] in_dir_x,
  input  logic signed [cmf_pkg::CoordWidth-1:0] in_dir_y,
  input  logic signed [cmf_pkg::CoordWidth-1:0] in_dir_z,
  output logic                                  out_valid,
  output logic [2:0]                            out_face,
  output logic [cmf_pkg::UvWidth-1:0]           out_tex_u,
  output logic [cmf_pkg::UvWidth-1:0]           out_tex_v,
  output logic                                  out_zero_vector
);

  cmf_pkg::cell_t              chain [cmf_pkg::UvWidth+1];
  cmf_pkg::cell_t              last;

  logic                        out_valid_r;
  logic [2:0]                  out_face_r, out_face_nxt;
  logic [cmf_pkg::UvWidth-1:0] out_tex_u_r, out_tex_u_nxt;
  logic [cmf_pkg::UvWidth-1:0] out_tex_v_r, out_tex_v_nxt;
  logic                        out_zero_r;

  assign busy = 1'b0;

  cmf_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (start && !busy),
    .dir_x    (in_dir_x),
    .dir_y    (in_dir_y),
    .dir_z    (in_dir_z),
    .cell_out (chain[0])
  );

  for (genvar i = 0; i < cmf_pkg::UvWidth; i++) begin : g_cell
    cmf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  assign last = chain[cmf_pkg::UvWidth];

  always_comb begin
    if (last.zero) begin
      out_face_nxt  = cmf_pkg::FACE_POS_X;
      out_tex_u_nxt = '0;
      out_tex_v_nxt = '0;
    end else begin
      out_face_nxt  = last.face;
      out_tex_u_nxt = last.sat_u ? '1 : last.quo_u;
      out_tex_v_nxt = last.sat_v ? '1 : last.quo_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_face_r  <= out_face_nxt;
    out_tex_u_r <= out_tex_u_nxt;
    out_tex_v_r <= out_tex_v_nxt;
    out_zero_r  <= last.zero;
  end

  assign out_valid       = out_valid_r;
  assign out_face        = out_face_r;
  assign out_tex_u       = out_tex_u_r;
  assign out_tex_v       = out_tex_v_r;
  assign out_zero_vector = out_zero_r;

endmodule

>>> hw/rtl/cmf_select.sv
module cmf_select (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  accept,
  input  logic signed [cmf_pkg::CoordWidth-1:0] dir_x,
  input  logic signed [cmf_pkg::CoordWidth-1:0] dir_y,
  input  logic signed [cmf_pkg::CoordWidth-1:0] dir_z,
  output cmf_pkg::cell_t                        cell_out
);

  logic [cmf_pkg::CoordWidth-1:0]    ax, ay, az;
  logic signed [cmf_pkg::SWidth-1:0] xe, ye, ze;
  logic signed [cmf_pkg::SWidth-1:0] sc_nxt, tc_nxt;
  logic [cmf_pkg::CoordWidth-1:0]    k_nxt;
  cmf_pkg::face_t                    face_nxt;
  logic                              zero_nxt;

  logic                              s1_valid_r;
  cmf_pkg::face_t                    s1_face_r;
  logic                              s1_zero_r;
  logic [cmf_pkg::CoordWidth-1:0]    s1_k_r;
  logic signed [cmf_pkg::SWidth-1:0] s1_sc_r, s1_tc_r;

  logic [cmf_pkg::RemWidth-1:0]      num_u, num_v, div;
  cmf_pkg::cell_t                    cell_nxt, cell_r;

  // major axis and face-local coordinates
  always_comb begin
    ax = dir_x[cmf_pkg::CoordWidth-1] ? -dir_x : dir_x;
    ay = dir_y[cmf_pkg::CoordWidth-1] ? -dir_y : dir_y;
    az = dir_z[cmf_pkg::CoordWidth-1] ? -dir_z : dir_z;
    xe = $signed({dir_x[cmf_pkg::CoordWidth-1], dir_x});
    ye = $signed({dir_y[cmf_pkg::CoordWidth-1], dir_y});
    ze = $signed({dir_z[cmf_pkg::CoordWidth-1], dir_z});
    zero_nxt = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
    priority if (az >= ax && az >= ay) begin
      k_nxt = az;
      if (dir_z[cmf_pkg::CoordWidth-1]) begin
        face_nxt = cmf_pkg::FACE_NEG_Z;
        sc_nxt   = -xe;
      end else begin
        face_nxt = cmf_pkg::FACE_POS_Z;
        sc_nxt   = xe;
      end
      tc_nxt = ye;
    end else if (ay >= ax) begin
      k_nxt  = ay;
      sc_nxt = xe;
      if (dir_y[cmf_pkg::CoordWidth-1]) begin
        face_nxt = cmf_pkg::FACE_NEG_Y;
        tc_nxt   = ze;
      end else begin
        face_nxt = cmf_pkg::FACE_POS_Y;
        tc_nxt   = -ze;
      end
    end else begin
      k_nxt  = ax;
      tc_nxt = ye;
      if (dir_x[cmf_pkg::CoordWidth-1]) begin
        face_nxt = cmf_pkg::FACE_NEG_X;
        sc_nxt   = ze;
      end else begin
        face_nxt = cmf_pkg::FACE_POS_X;
        sc_nxt   = -ze;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_face_r <= face_nxt;
    s1_zero_r <= zero_nxt;
    s1_k_r    <= k_nxt;
    s1_sc_r   <= sc_nxt;
    s1_tc_r   <= tc_nxt;
  end

  // numerator s + k lies in [0, 2k]; unsigned wrap gives it exactly
  always_comb begin
    num_u = cmf_pkg::RemWidth'(s1_sc_r) + {1'b0, s1_k_r};
    num_v = cmf_pkg::RemWidth'(s1_tc_r) + {1'b0, s1_k_r};
    div   = {s1_k_r, 1'b0};
    cell_nxt.valid = s1_valid_r;
    cell_nxt.face  = s1_face_r;
    cell_nxt.zero  = s1_zero_r;
    cell_nxt.div   = div;
    // numerator equal to the divisor means exactly 1.0
    cell_nxt.sat_u = (num_u == div);
    cell_nxt.sat_v = (num_v == div);
    cell_nxt.rem_u = cell_nxt.sat_u ? '0 : num_u;
    cell_nxt.rem_v = cell_nxt.sat_v ? '0 : num_v;
    cell_nxt.quo_u = '0;
    cell_nxt.quo_v = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

>>> hw/rtl/cmf_cell.sv
module cmf_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  cmf_pkg::cell_t cell_in,
  output cmf_pkg::cell_t cell_out
);

  logic [cmf_pkg::RemWidth:0] rem2_u, rem2_v, div_ext, diff_u, diff_v;
  logic                       ge_u, ge_v;
  cmf_pkg::cell_t             cell_nxt, cell_r;

  // one restoring step for each of the two coordinates
  always_comb begin
    div_ext = {1'b0, cell_in.div};
    rem2_u  = {cell_in.rem_u, 1'b0};
    rem2_v  = {cell_in.rem_v, 1'b0};
    ge_u    = rem2_u >= div_ext;
    ge_v    = rem2_v >= div_ext;
    diff_u  = rem2_u - div_ext;
    diff_v  = rem2_v - div_ext;
    cell_nxt       = cell_in;
    cell_nxt.rem_u = ge_u ? diff_u[cmf_pkg::RemWidth-1:0] : rem2_u[cmf_pkg::RemWidth-1:0];
    cell_nxt.rem_v = ge_v ? diff_v[cmf_pkg::RemWidth-1:0] : rem2_v[cmf_pkg::RemWidth-1:0];
    cell_nxt.quo_u = {cell_in.quo_u[cmf_pkg::UvWidth-2:0], ge_u};
    cell_nxt.quo_v = {cell_in.quo_v[cmf_pkg::UvWidth-2:0], ge_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

>>> hw/rtl/cmf_checker.sv
module cmf_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  start,
  input logic                                  busy,
  input logic signed [cmf_pkg::CoordWidth-1:0] in_dir_x,
  input logic signed [cmf_pkg::CoordWidth-1:0] in_dir_y,
  input logic signed [cmf_pkg::CoordWidth-1:0] in_dir_z,
  input logic                                  out_valid,
  input logic [2:0]                            out_face,
  input logic [cmf_pkg::UvWidth-1:0]           out_tex_u,
  input logic [cmf_pkg::UvWidth-1:0]           out_tex_v,
  input logic                                  out_zero_vector
);

  // every input transfer yields a result a fixed time later
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(cmf_pkg::Latency) out_valid)
    else $error("missing result after input transfer");

  // no result without a matching input transfer
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, cmf_pkg::Latency))
    else $error("result without input transfer");

  // zero flag follows the input that caused it
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_zero_vector == $past(in_dir_x == '0 && in_dir_y == '0
                                             && in_dir_z == '0, cmf_pkg::Latency)))
    else $error("zero flag does not match input");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_vector) |->
      (out_face == cmf_pkg::FACE_POS_X && out_tex_u == '0 && out_tex_v == '0))
    else $error("zero vector result not cleared");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_face <= cmf_pkg::FACE_NEG_Z))
    else $error("face out of range");

endmodule

bind cube_map_face_and_uv cmf_checker u_cmf_checker (.*);

>>> bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [cmf_pkg::CoordWidth-1:0] x;
    logic signed [cmf_pkg::CoordWidth-1:0] y;
    logic signed [cmf_pkg::CoordWidth-1:0] z;
  } direction_t;

  typedef struct packed {
    cmf_pkg::face_t              face;
    logic [cmf_pkg::UvWidth-1:0] u;
    logic [cmf_pkg::UvWidth-1:0] v;
    logic                        zero;
  } face_uv_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  start = 1'b0;
  logic                                  busy;
  logic signed [cmf_pkg::CoordWidth-1:0] in_dir_x = '0;
  logic signed [cmf_pkg::CoordWidth-1:0] in_dir_y = '0;
  logic signed [cmf_pkg::CoordWidth-1:0] in_dir_z = '0;
  logic                                  out_valid;
  logic [2:0]                            out_face;
  logic [cmf_pkg::UvWidth-1:0]           out_tex_u;
  logic [cmf_pkg::UvWidth-1:0]           out_tex_v;
  logic                                  out_zero_vector;

  direction_t dir_pending[$];
  face_uv_t   uv_expected[$];
  int         send_idle_pct = 0;
  int         mismatches = 0;

  cube_map_face_and_uv i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_dir_x       (in_dir_x),
    .in_dir_y       (in_dir_y),
    .in_dir_z       (in_dir_z),
    .out_valid      (out_valid),
    .out_face       (out_face),
    .out_tex_u      (out_tex_u),
    .out_tex_v      (out_tex_v),
    .out_zero_vector(out_zero_vector)
  );

  always #4 clk = ~clk;

  // (s + k) / 2k as an unsigned fraction, truncated, saturated below 1.0
  function automatic logic [cmf_pkg::UvWidth-1:0] face_fraction(
      logic signed [cmf_pkg::SWidth-1:0] s, logic [cmf_pkg::SWidth-1:0] k);
    logic signed [cmf_pkg::SWidth+1:0]         sum;
    logic [cmf_pkg::SWidth+cmf_pkg::UvWidth:0] num;
    logic [cmf_pkg::SWidth+cmf_pkg::UvWidth:0] quo;
    logic [cmf_pkg::SWidth:0]                  den;
    sum = s + $signed({1'b0, k});
    num = {sum[cmf_pkg::SWidth:0], {cmf_pkg::UvWidth{1'b0}}};
    den = {k, 1'b0};
    quo = num / den;
    if (quo > {cmf_pkg::UvWidth{1'b1}}) begin
      return {cmf_pkg::UvWidth{1'b1}};
    end
    return quo[cmf_pkg::UvWidth-1:0];
  endfunction

  function automatic face_uv_t map_direction(direction_t d);
    logic signed [cmf_pkg::SWidth-1:0] wx, wy, wz, sc, tc;
    logic [cmf_pkg::SWidth-1:0]        ax, ay, az, k;
    face_uv_t                          r;
    wx = d.x;
    wy = d.y;
    wz = d.z;
    ax = (wx < 0) ? -wx : wx;
    ay = (wy < 0) ? -wy : wy;
    az = (wz < 0) ? -wz : wz;
    r = '0;
    if (d.x == 0 && d.y == 0 && d.z == 0) begin
      r.zero = 1'b1;
      return r;
    end
    // ties go to z first, then y over x
    if (az >= ax && az >= ay) begin
      k = az;
      if (wz < 0) begin
        r.face = cmf_pkg::FACE_NEG_Z; sc = -wx; tc = wy;
      end else begin
        r.face = cmf_pkg::FACE_POS_Z; sc = wx;  tc = wy;
      end
    end else if (ay >= ax) begin
      k = ay;
      if (wy < 0) begin
        r.face = cmf_pkg::FACE_NEG_Y; sc = wx; tc = wz;
      end else begin
        r.face = cmf_pkg::FACE_POS_Y; sc = wx; tc = -wz;
      end
    end else begin
      k = ax;
      if (wx < 0) begin
        r.face = cmf_pkg::FACE_NEG_X; sc = wz;  tc = wy;
      end else begin
        r.face = cmf_pkg::FACE_POS_X; sc = -wz; tc = wy;
      end
    end
    r.u = face_fraction(sc, k);
    r.v = face_fraction(tc, k);
    return r;
  endfunction

  function automatic logic signed [cmf_pkg::CoordWidth-1:0] pick_component();
    logic signed [cmf_pkg::CoordWidth-1:0] c;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(5))
          0: c = '0;
          1: c = {1'b1, {(cmf_pkg::CoordWidth-1){1'b0}}};
          2: c = {1'b0, {(cmf_pkg::CoordWidth-1){1'b1}}};
          3: c = '1;
          4: c = {{(cmf_pkg::CoordWidth-1){1'b0}}, 1'b1};
          default: c = cmf_pkg::CoordWidth'($urandom_range(64) - 32);
        endcase
      end
      1: c = cmf_pkg::CoordWidth'($urandom_range(2000) - 1000);
      default: c = cmf_pkg::CoordWidth'($urandom);
    endcase
    return c;
  endfunction

  function automatic direction_t random_direction();
    direction_t d;
    logic signed [cmf_pkg::CoordWidth-1:0] src;
    d.x = pick_component();
    d.y = pick_component();
    d.z = pick_component();
    // force magnitude ties between two components now and then
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(2))
        0: src = d.x;
        1: src = d.y;
        default: src = d.z;
      endcase
      if ($urandom_range(1) == 1) begin
        src = -src;
      end
      case ($urandom_range(2))
        0: d.x = src;
        1: d.y = src;
        default: d.z = src;
      endcase
    end
    if ($urandom_range(49) == 0) begin
      d = '0;
    end
    return d;
  endfunction

  task automatic add_direction(int x, int y, int z);
    direction_t d;
    d.x = cmf_pkg::CoordWidth'(x);
    d.y = cmf_pkg::CoordWidth'(y);
    d.z = cmf_pkg::CoordWidth'(z);
    dir_pending.push_back(d);
  endtask

  // driver
  always @(posedge clk) begin
    direction_t d;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        d.x = in_dir_x;
        d.y = in_dir_y;
        d.z = in_dir_z;
        uv_expected.push_back(map_direction(d));
      end
      if (!start || !busy) begin
        if (dir_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          d = dir_pending.pop_front();
          start    <= 1'b1;
          in_dir_x <= d.x;
          in_dir_y <= d.y;
          in_dir_z <= d.z;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    face_uv_t e;
    if (rst_n && out_valid === 1'b1) begin
      if (uv_expected.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result face %0d u %0d v %0d zero %0b", $time,
                 out_face, out_tex_u, out_tex_v, out_zero_vector);
      end else begin
        e = uv_expected.pop_front();
        if (out_face !== e.face || out_tex_u !== e.u || out_tex_v !== e.v ||
            out_zero_vector !== e.zero) begin
          mismatches++;
          $display("%0t: mismatch exp face %0d u %0d v %0d zero %0b,",
                   $time, e.face, e.u, e.v, e.zero,
                   " got face %0d u %0d v %0d zero %0b",
                   out_face, out_tex_u, out_tex_v, out_zero_vector);
        end
      end
    end
  end

  initial begin
    int phase_idle[4];
    phase_idle = '{0, 70, 16, 0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    add_direction(0, 0, 0);
    add_direction(16384, 0, 0);
    add_direction(-16384, 0, 0);
    add_direction(0, 16384, 0);
    add_direction(0, -16384, 0);
    add_direction(0, 0, 16384);
    add_direction(0, 0, -16384);
    add_direction(32767, 32767, 32767);
    add_direction(-32768, -32768, -32768);
    add_direction(-32768, 0, 0);
    add_direction(0, -32768, 1);
    add_direction(0, 0, -32768);
    add_direction(100, 100, 50);
    add_direction(-100, 100, 50);
    add_direction(100, -100, -50);
    add_direction(200, 5, 200);
    add_direction(-200, 5, -200);
    add_direction(5, 300, -300);
    add_direction(32767, -32768, 5);
    add_direction(1, 0, 0);
    add_direction(0, 0, -1);
    add_direction(32767, -1, 1);
    add_direction(-1, -1, -1);
    add_direction(12345, -6789, 2222);
    add_direction(-32768, 32767, -32768);

    for (int p = 0; p < 4; p++) begin
      @(negedge clk);
      send_idle_pct = phase_idle[p];
      for (int i = 0; i < 100; i++) begin
        dir_pending.push_back(random_direction());
      end
      while (dir_pending.size() != 0) @(negedge clk);
    end

    while (start || uv_expected.size() != 0) @(negedge clk);
    repeat (cmf_pkg::Latency + 8) @(posedge clk);
    if (mismatches == 0 && uv_expected.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
